>>> hw/rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and helpers for the HEX record decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

	// Result kinds carried on the result stream's tuser.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_OK   = 2'd1,
		KIND_FAIL = 2'd2
	} ihex_kind_t;

	// Decoder phases, one-hot.
	typedef enum logic [4:0] {
		PH_HUNT   = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_DATA   = 5'b00100,
		PH_CHECK  = 5'b01000,
		PH_DONE   = 5'b10000
	} ihex_phase_t;

	localparam logic [7:0] COLON_CHAR = 8'h3A;

	// Header byte positions (odd character index completes a byte).
	localparam logic [8:0] HDR_IDX_COUNT = 9'd1;
	localparam logic [8:0] HDR_IDX_TYPE  = 9'd7;

	localparam logic [7:0] REC_TYPE_DATA = 8'h00;
	localparam logic [7:0] REC_TYPE_END  = 8'h01;

	// Classified character handed from front to back.
	typedef struct packed {
		logic [3:0] nib;
		logic       colon;
		logic       last;
	} ihex_item_t;

	// Hex digit value; anything else reads as zero.
	function automatic logic [3:0] ihex_nibble(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30;
			end else if (c >= 8'h41 && c <= 8'h46) begin
				d = c - 8'h37;
			end else if (c >= 8'h61 && c <= 8'h66) begin
				d = c - 8'h57;
			end
			return d[3:0];
		end
	endfunction

endpackage

>>> hw/rtl/ihex_front.sv
// ----------------------------------------------------------------------------
// ihex_front
// Accept characters and classify them into nibble, colon and end flags.
// ----------------------------------------------------------------------------
module ihex_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] char_in
	input  logic                 s_tlast,
	output logic                 item_valid,
	output ihex_pkg::ihex_item_t item,
	input  logic                 item_ready
);

	logic                 valid_s1;
	ihex_pkg::ihex_item_t item_s1;

	assign s_tready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.nib   <= ihex_pkg::ihex_nibble(s_tdata);
			item_s1.colon <= (s_tdata == ihex_pkg::COLON_CHAR);
			item_s1.last  <= s_tlast;
		end
	end

endmodule

>>> hw/rtl/ihex_queue.sv
// ----------------------------------------------------------------------------
// ihex_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module ihex_queue #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ihex_pkg::ihex_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output ihex_pkg::ihex_item_t pop_item
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

	ihex_pkg::ihex_item_t mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [CntW-1:0]      count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != CntFull);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/ihex_back.sv
// ----------------------------------------------------------------------------
// ihex_back
// Record state machine: pair nibbles, track sum, emit bytes and outcomes.
// ----------------------------------------------------------------------------
module ihex_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  ihex_pkg::ihex_item_t item,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,
	output logic [1:0]           m_tuser
);

	ihex_pkg::ihex_phase_t phase_q, phase_d;
	logic [8:0]            idx_q, idx_d;
	logic [7:0]            len_q, len_d;
	logic [7:0]            rk_q, rk_d;
	logic [7:0]            sum_q, sum_d;
	logic [3:0]            hn_q, hn_d;
	logic                  seen_q, seen_d;

	logic                  res_valid;
	ihex_pkg::ihex_kind_t  res_kind;
	logic [7:0]            res_byte;

	logic [7:0]            byte_val;
	logic [9:0]            idx_inc;
	logic [7:0]            sum_neg;
	logic                  take;

	logic                  out_valid_q;
	ihex_pkg::ihex_kind_t  out_kind_q;
	logic [7:0]            out_byte_q;

	assign item_ready = !out_valid_q || m_tready;
	assign take       = item_valid && item_ready;
	assign byte_val   = {hn_q, item.nib};
	assign idx_inc    = {1'b0, idx_q} + 10'd1;
	assign sum_neg    = ~sum_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		idx_d     = idx_q;
		len_d     = len_q;
		rk_d      = rk_q;
		sum_d     = sum_q;
		hn_d      = hn_q;
		seen_d    = seen_q;
		res_valid = 1'b0;
		res_kind  = ihex_pkg::KIND_DATA;
		res_byte  = 8'd0;

		unique case (phase_q) inside
			ihex_pkg::PH_HUNT: begin
				if (item.colon) begin
					phase_d = ihex_pkg::PH_HEADER;
					idx_d   = 9'd0;
					sum_d   = 8'd0;
					len_d   = 8'd0;
					rk_d    = 8'd0;
					hn_d    = 4'd0;
				end
			end
			ihex_pkg::PH_HEADER, ihex_pkg::PH_DATA, ihex_pkg::PH_CHECK: begin
				if (!idx_q[0]) begin
					hn_d  = item.nib;
					idx_d = idx_inc[8:0];
				end else if (phase_q == ihex_pkg::PH_HEADER) begin
					sum_d = sum_q + byte_val;
					if (idx_q == ihex_pkg::HDR_IDX_COUNT) begin
						len_d = byte_val;
					end
					if (idx_q == ihex_pkg::HDR_IDX_TYPE) begin
						rk_d  = byte_val;
						idx_d = 9'd0;
						if (byte_val == ihex_pkg::REC_TYPE_END) begin
							res_valid = 1'b1;
							res_kind  = seen_q ? ihex_pkg::KIND_OK : ihex_pkg::KIND_FAIL;
							phase_d   = ihex_pkg::PH_DONE;
						end else if (len_q == 8'd0) begin
							phase_d = ihex_pkg::PH_CHECK;
						end else begin
							phase_d = ihex_pkg::PH_DATA;
						end
					end else begin
						idx_d = idx_inc[8:0];
					end
				end else if (phase_q == ihex_pkg::PH_DATA) begin
					sum_d = sum_q + byte_val;
					if (rk_q == ihex_pkg::REC_TYPE_DATA) begin
						res_valid = 1'b1;
						res_kind  = ihex_pkg::KIND_DATA;
						res_byte  = byte_val;
						seen_d    = 1'b1;
					end
					// End of data once the count's worth of characters is in.
					if (idx_inc >= {1'b0, len_q, 1'b0}) begin
						phase_d = ihex_pkg::PH_CHECK;
						idx_d   = 9'd0;
					end else begin
						idx_d = idx_inc[8:0];
					end
				end else begin
					idx_d = 9'd0;
					if (rk_q == ihex_pkg::REC_TYPE_DATA && byte_val != sum_neg) begin
						res_valid = 1'b1;
						res_kind  = ihex_pkg::KIND_FAIL;
						res_byte  = 8'd0;
						phase_d   = ihex_pkg::PH_DONE;
					end else begin
						phase_d = ihex_pkg::PH_HUNT;
					end
				end
			end
			ihex_pkg::PH_DONE: begin
				// Hold: ignore characters until the end of the file.
			end
			default: begin
				phase_d = ihex_pkg::PH_HUNT;
			end
		endcase

		// End of file: fail if no outcome yet, then clear everything.
		if (item.last) begin
			if (phase_d != ihex_pkg::PH_DONE) begin
				res_valid = 1'b1;
				res_kind  = ihex_pkg::KIND_FAIL;
				res_byte  = 8'd0;
			end
			phase_d = ihex_pkg::PH_HUNT;
			idx_d   = 9'd0;
			len_d   = 8'd0;
			rk_d    = 8'd0;
			sum_d   = 8'd0;
			hn_d    = 4'd0;
			seen_d  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ihex_pkg::PH_HUNT;
			idx_q       <= 9'd0;
			len_q       <= 8'd0;
			rk_q        <= 8'd0;
			sum_q       <= 8'd0;
			hn_q        <= 4'd0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q     <= phase_d;
				idx_q       <= idx_d;
				len_q       <= len_d;
				rk_q        <= rk_d;
				sum_q       <= sum_d;
				hn_q        <= hn_d;
				seen_q      <= seen_d;
				out_valid_q <= res_valid;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			out_kind_q <= res_kind;
			out_byte_q <= res_byte;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_kind_q;

endmodule

>>> hw/rtl/intel_hex_record_decoder.sv
// Path: an accepted character's result, if any, passes the front register, a queue entry
//   and the result register before it leaves on the result stream.
// Throughput: one character per cycle unless a stalled result side holds a result back;
//   the record state update in the back end is the only per-character loop.
// Reset: arst_n low clears the front register, queue pointers, record state and the
//   result valid; the decoder restarts hunting for a colon.
// ----------------------------------------------------------------------------
// intel_hex_record_decoder
// Decode HEX file text into data bytes plus a final ok/fail outcome.
// ----------------------------------------------------------------------------
module intel_hex_record_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// Character stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_in
	input  logic       s_tlast,   // last_char: final character of the file
	// Result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte (zero unless kind is data)
	output logic [1:0] m_tuser    // [1:0] kind: data, ok or fail
);

	// Front to queue.
	logic                 fq_valid;
	logic                 fq_ready;
	ihex_pkg::ihex_item_t fq_item;

	// Queue to back.
	logic                 qb_valid;
	logic                 qb_ready;
	ihex_pkg::ihex_item_t qb_item;

	// Classify each character as soon as it is accepted: nibble value,
	// colon mark and end-of-file flag travel together as one item.
	ihex_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.item_valid (fq_valid),
		.item       (fq_item),
		.item_ready (fq_ready)
	);

	// Buffer classified items so a stalled result side does not stall
	// the character side right away.
	ihex_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_item  (fq_item),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item)
	);

	// Walk the record: header, data, checksum. Emit data bytes of data
	// records, fail on a data record's checksum mismatch or at end of
	// file with no outcome, and report the outcome on the end record.
	// Items advance while the result register is empty or being taken.
	ihex_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (qb_valid),
		.item_ready (qb_ready),
		.item       (qb_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

>>> hw/rtl/ihex_checker.sv
// ----------------------------------------------------------------------------
// ihex_checker
// Port-level checks for the HEX record decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ihex_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser
);

	// Hold a stalled result transaction unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result transaction changed while stalled");

	// Only the three defined kinds leave the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ihex_pkg::KIND_DATA || m_tuser == ihex_pkg::KIND_OK ||
			m_tuser == ihex_pkg::KIND_FAIL))
		else $error("undefined result kind");

	// Outcome transactions carry a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ihex_pkg::KIND_DATA |-> m_tdata == 8'd0)
		else $error("outcome transaction with nonzero data byte");

	// No result in the cycle after reset was held.
	assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid after reset");

endmodule

bind intel_hex_record_decoder ihex_checker u_ihex_checker (.*);
